// File: design/mbwm_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update of the
// write-multiple-registers framer. No dependencies.
package mbwm_pkg;

   localparam int MaxRegisters = 16;
   localparam int CntW = 5;

   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'hA001;
   localparam logic [7:0] FuncWriteMulti = 8'h10;
   localparam logic [7:0] NodeReset = 8'h01;
   localparam logic [CntW-1:0] CountReset = CntW'(MaxRegisters);

   typedef enum logic [1:0] {
      CsrNodeAddress   = 2'd0,
      CsrStartAddress  = 2'd1,
      CsrRegisterCount = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      PosNode      = 4'd0,
      PosFunc      = 4'd1,
      PosStartHi   = 4'd2,
      PosStartLo   = 4'd3,
      PosCountHi   = 4'd4,
      PosCountLo   = 4'd5,
      PosByteCount = 4'd6,
      PosValueHi   = 4'd7,
      PosValueLo   = 4'd8,
      PosCrcLo     = 4'd9,
      PosCrcHi     = 4'd10
   } pos_type;

   typedef struct packed {
      logic [15:0]     value;
      logic            first;
      logic            last;
      logic [7:0]      node;
      logic [15:0]     start;
      logic [CntW-1:0] count;
   } mbwm_entry_type;

   function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: design/modbus_write_multiple_framer_top.sv
// Modbus RTU write-multiple-registers framer, top level.
// Instantiates mbwm_front, mbwm_queue and mbwm_back; depends on mbwm_pkg.
//
// Each accepted 16-bit value yields its frame bytes, one beat per cycle
// from a registered output unless rsp_tready stalls it: 2 beats for a
// mid-frame value, 7 more for the header on the first value of a frame,
// 2 more for the CRC after the last. The byte sequencer in the back end
// sets the rate at which values stream; a 2-entry queue lets input keep
// flowing while output stalls, until it fills. Frame end rides on
// rsp_tlast, last beat of a value on rsp_tuser. Configuration writes are
// taken every cycle and belong in idle periods; register count is clamped
// to 1..16 and header fields are sampled on the first value of each frame.
module modbus_write_multiple_framer_top import mbwm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] reg_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] frame_byte
   output logic        rsp_tlast,   // frame_end
   output logic        rsp_tuser    // [0] run_last
);

   logic           queue_full;
   logic           push;
   mbwm_entry_type push_entry;
   logic           pop;
   logic           head_valid;
   mbwm_entry_type head_entry;

   mbwm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   mbwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   mbwm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: design/mbwm_front.sv
// Front end: holds the configuration registers, tracks the value index
// within a frame and tags each accepted value. Depends on mbwm_pkg.
module mbwm_front import mbwm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  logic [1:0]     csr_index,
   input  logic [15:0]    csr_data,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [15:0]    req_tdata,   // [15:0] reg_value
   input  logic           queue_full,
   output logic           push,
   output mbwm_entry_type push_entry
);

   logic [7:0]      node_ff;
   logic [15:0]     start_ff;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] index_ff, index_in;
   logic [CntW-1:0] count_use;
   logic [CntW-1:0] index_next;
   logic            last;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff  <= NodeReset;
         start_ff <= 16'h0000;
         count_ff <= CountReset;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CsrNodeAddress:   node_ff  <= csr_data[7:0];
            CsrStartAddress:  start_ff <= csr_data;
            CsrRegisterCount: count_ff <= csr_data[CntW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (count_ff == '0) begin
         count_use = CntW'(1);
      end else if (count_ff > CntW'(MaxRegisters)) begin
         count_use = CntW'(MaxRegisters);
      end else begin
         count_use = count_ff;
      end
      index_next = index_ff + CntW'(1);
      last       = index_next >= count_use;
      req_tready = !queue_full;
      push       = req_tvalid && !queue_full;
      index_in   = push ? (last ? '0 : index_next) : index_ff;
      push_entry.value = req_tdata;
      push_entry.first = index_ff == '0;
      push_entry.last  = last;
      push_entry.node  = node_ff;
      push_entry.start = start_ff;
      push_entry.count = count_use;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
      end else begin
         index_ff <= index_in;
      end
   end

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      index_ff < CntW'(MaxRegisters))
      else $error("value index out of range");

   a_first_restart: assert property (@(posedge clock) disable iff (reset)
      push && push_entry.last |=> index_ff == '0)
      else $error("index not cleared after last value");

   a_last_count: assert property (@(posedge clock) disable iff (reset)
      push && push_entry.first && push_entry.count == CntW'(1) |-> push_entry.last)
      else $error("single-value frame not marked last");

endmodule

// File: design/mbwm_queue.sv
// Two-entry queue of tagged values between the front and back ends.
// Depends on mbwm_pkg.
module mbwm_queue import mbwm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  mbwm_entry_type push_entry,
   output logic           full,
   input  logic           pop,
   output logic           head_valid,
   output mbwm_entry_type head_entry
);

   mbwm_entry_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      full       = count_ff == 2'd2;
      head_valid = count_ff != 2'd0;
      head_entry = mem_ff[rd_ptr_ff];
      wr_ptr_in  = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in   = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

endmodule

// File: design/mbwm_back.sv
// Back end: walks each queued value through its frame bytes, one byte per
// beat, keeps the running CRC and drives the output register.
// Depends on mbwm_pkg.
module mbwm_back import mbwm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           head_valid,
   input  mbwm_entry_type head_entry,
   output logic           pop,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [7:0]     rsp_tdata,   // [7:0] frame_byte
   output logic           rsp_tlast,   // frame_end
   output logic           rsp_tuser    // [0] run_last
);

   logic       started_ff, started_in;
   pos_type    pos_ff, pos_in;
   pos_type    pos_cur;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] crc_cur;
   logic [7:0] data_byte;
   logic       final_byte;
   logic       emit;
   logic       out_adv;
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0] rsp_tdata_ff, rsp_tdata_in;
   logic       rsp_tlast_ff, rsp_tlast_in;
   logic       rsp_tuser_ff, rsp_tuser_in;

   always_comb begin
      if (started_ff) begin
         pos_cur = pos_ff;
      end else begin
         pos_cur = head_entry.first ? PosNode : PosValueHi;
      end
      crc_cur = (pos_cur == PosNode) ? CrcInit : crc_ff;
      unique case (pos_cur)
         PosNode:      data_byte = head_entry.node;
         PosFunc:      data_byte = FuncWriteMulti;
         PosStartHi:   data_byte = head_entry.start[15:8];
         PosStartLo:   data_byte = head_entry.start[7:0];
         PosCountHi:   data_byte = 8'h00;
         PosCountLo:   data_byte = 8'(head_entry.count);
         PosByteCount: data_byte = 8'({head_entry.count, 1'b0});
         PosValueHi:   data_byte = head_entry.value[15:8];
         PosValueLo:   data_byte = head_entry.value[7:0];
         PosCrcLo:     data_byte = crc_ff[7:0];
         PosCrcHi:     data_byte = crc_ff[15:8];
         default:      data_byte = 8'h00;
      endcase
      final_byte = (pos_cur == PosValueLo && !head_entry.last) || pos_cur == PosCrcHi;
      out_adv    = !rsp_tvalid_ff || rsp_tready;
      emit       = head_valid && out_adv;
      pop        = emit && final_byte;

      started_in = started_ff;
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      if (emit) begin
         started_in = !final_byte;
         pos_in     = pos_type'(pos_cur + 4'd1);
         if (pos_cur != PosCrcLo && pos_cur != PosCrcHi) begin
            crc_in = crc_update(crc_cur, data_byte);
         end
      end

      rsp_tvalid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid_ff);
      rsp_tdata_in  = emit ? data_byte : rsp_tdata_ff;
      rsp_tlast_in  = emit ? (pos_cur == PosCrcHi) : rsp_tlast_ff;
      rsp_tuser_in  = emit ? final_byte : rsp_tuser_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff    <= 1'b0;
         pos_ff        <= PosNode;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         started_ff    <= started_in;
         pos_ff        <= pos_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff       <= crc_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("frame end not marked as last beat of run");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> pos_ff <= PosCrcHi)
      else $error("byte position out of range");

   a_crc_after_last: assert property (@(posedge clock) disable iff (reset)
      emit && pos_cur == PosCrcLo |-> head_entry.last)
      else $error("CRC emitted for a value that does not end a frame");

endmodule
